FILE: rtl/core/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg: shared types and constants for the streaming sha-256 hasher
// round constants, initial hash values, queue entry and engine states
// ----------------------------------------------------------------------------
package s256_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueueAw    = 2;

	// one queued item from the front part
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} q_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_EMIT
	} eng_state_t;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

FILE: rtl/core/s256_if.sv
// ----------------------------------------------------------------------------
// s256_in_if / s256_out_if: valid-ready channels of the sha-256 hasher
// input carries one byte item, output carries one digest word item
// ----------------------------------------------------------------------------
interface s256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       message_end;
	modport source (output valid, data_byte, byte_present, message_end, input ready);
	modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface s256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha256_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_top: streaming sha-256 hasher
//  channel | dir | carries
//  in_ch   | in  | data_byte, byte_present, message_end
//  out_ch  | out | digest_word, word_index, last_word
// a byte item is taken while the engine idles; a full block then runs compression
// (64 rounds at one per cycle in the shared round unit, then the chaining add)
// an end mark adds one or two padding blocks, each with pad step, rounds and add,
// then the eight digest words go out; a four-entry queue absorbs input meanwhile
// reset clears control state and loads the initial hash; no clearing pass
// ----------------------------------------------------------------------------
module sha256_stream_hash_top (
	input  logic       clk,
	input  logic       arst_n,
	s256_in_if.sink    in_ch,
	s256_out_if.source out_ch
);

	logic               q_valid, q_pop;
	s256_pkg::q_entry_t q_data;

	s256_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_valid(q_valid),
		.q_data (q_data),
		.q_pop  (q_pop)
	);

	s256_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_data (q_data),
		.q_pop  (q_pop),
		.out_ch (out_ch)
	);

	// a pop needs a queued item
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	// last word only at index seven
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
		else $error("last word mismatch");

endmodule

FILE: rtl/core/s256_front.sv
// ----------------------------------------------------------------------------
// s256_front: input classification and item queue
// drops empty items and buffers the rest for the compression engine
// ----------------------------------------------------------------------------
module s256_front (
	input  logic               clk,
	input  logic               arst_n,
	s256_in_if.sink            in_ch,
	output logic               q_valid,
	output s256_pkg::q_entry_t q_data,
	input  logic               q_pop
);

	s256_pkg::q_entry_t         mem_q [s256_pkg::QueueDepth];
	logic [s256_pkg::QueueAw-1:0] wr_q, rd_q;
	logic [s256_pkg::QueueAw:0]   cnt_q;
	logic push, useful;

	// items with neither byte nor end mark do nothing
	assign useful      = in_ch.byte_present | in_ch.message_end;
	assign in_ch.ready = (cnt_q != 3'(s256_pkg::QueueDepth));
	assign push        = in_ch.valid & in_ch.ready & useful;
	assign q_valid     = (cnt_q != '0);
	assign q_data      = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{in_ch.data_byte, in_ch.byte_present, in_ch.message_end};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end

endmodule

FILE: rtl/core/s256_engine.sv
// ----------------------------------------------------------------------------
// s256_engine: block gathering, padding and 64-round compression
// one round per cycle, then digest words out, read straight from the chaining register
// ----------------------------------------------------------------------------
module s256_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  s256_pkg::q_entry_t q_data,
	output logic               q_pop,
	s256_out_if.source         out_ch
);

	s256_pkg::eng_state_t state_q, state_d;
	logic [31:0] chain_q [8];
	logic [31:0] wk_q [8];
	logic [31:0] blk_q [16];
	logic [63:0] bits_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        last_blk_q;
	logic        zero_blk_q;
	logic [2:0]  oidx_q;

	logic [31:0] w_cur, w_new, t1, t2, s0, s1;
	logic        take, start_comp, pad_now;
	logic [31:0] w2, w15;

	// schedule word: first 16 rounds read the block, later ones extend it
	assign w2    = blk_q[14];
	assign w15   = blk_q[1];
	assign s1    = s256_pkg::rotr(w2, 17) ^ s256_pkg::rotr(w2, 19) ^ (w2 >> 10);
	assign s0    = s256_pkg::rotr(w15, 7) ^ s256_pkg::rotr(w15, 18) ^ (w15 >> 3);
	assign w_new = s1 + blk_q[9] + s0 + blk_q[0];
	assign w_cur = (rnd_q < 6'd16) ? blk_q[0] : w_new;

	assign t1 = wk_q[7] + (s256_pkg::rotr(wk_q[4], 6) ^ s256_pkg::rotr(wk_q[4], 11)
		^ s256_pkg::rotr(wk_q[4], 25)) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
		+ s256_pkg::RoundK[rnd_q] + w_cur;
	assign t2 = (s256_pkg::rotr(wk_q[0], 2) ^ s256_pkg::rotr(wk_q[0], 13)
		^ s256_pkg::rotr(wk_q[0], 22))
		+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

	assign take  = (state_q == s256_pkg::ST_IDLE) && q_valid;
	assign q_pop = take;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			s256_pkg::ST_IDLE: if (take) begin
				if (q_data.byte_present && fill_q == 6'd63) state_d = s256_pkg::ST_ROUND;
				else if (q_data.message_end) state_d = s256_pkg::ST_PAD;
			end
			s256_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = s256_pkg::ST_FINAL;
			s256_pkg::ST_FINAL: begin
				if (last_blk_q) state_d = s256_pkg::ST_EMIT;
				else if (pad_now || zero_blk_q) state_d = s256_pkg::ST_PAD;
				else state_d = s256_pkg::ST_IDLE;
			end
			s256_pkg::ST_PAD: state_d = s256_pkg::ST_ROUND;
			s256_pkg::ST_EMIT:
				if (out_ch.ready && oidx_q == 3'd7) state_d = s256_pkg::ST_IDLE;
			default: state_d = s256_pkg::ST_IDLE;
		endcase
	end

	assign start_comp = (state_q == s256_pkg::ST_PAD) ||
		(take && q_data.byte_present && fill_q == 6'd63);

	// pending end mark: set when a byte with the end mark is taken, cleared by padding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_now <= 1'b0;
		else if (take) pad_now <= q_data.message_end && q_data.byte_present;
		else if (state_q == s256_pkg::ST_PAD) pad_now <= 1'b0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= s256_pkg::ST_IDLE;
			bits_q     <= '0;
			fill_q     <= '0;
			rnd_q      <= '0;
			last_blk_q <= 1'b0;
			zero_blk_q <= 1'b0;
			oidx_q     <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= s256_pkg::InitHash[i];
		end else begin
			state_q <= state_d;
			if (take && q_data.byte_present) begin
				bits_q <= bits_q + 64'd8;
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == s256_pkg::ST_PAD) begin
				// fill_q < 56: pad byte, zeros, length; else pad, zeros only
				last_blk_q <= (fill_q < s256_pkg::LenPos);
				// no room for the length: a block of zeros and length follows
				zero_blk_q <= (fill_q >= s256_pkg::LenPos);
				fill_q     <= '0;
			end
			if (start_comp) rnd_q <= '0;
			else if (state_q == s256_pkg::ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == s256_pkg::ST_FINAL) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wk_q[i];
			end
			if (state_q == s256_pkg::ST_EMIT && out_ch.ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) chain_q[i] <= s256_pkg::InitHash[i];
					bits_q     <= '0;
					fill_q     <= '0;
					last_blk_q <= 1'b0;
				end
			end
		end
	end

	// block words, working variables
	always_ff @(posedge clk) begin
		if (take && q_data.byte_present) begin
			blk_q[fill_q[5:2]] <= {blk_q[fill_q[5:2]][23:0], q_data.data_byte};
		end
		if (state_q == s256_pkg::ST_PAD) begin
			// fill_q bytes held; place pad byte, zeros and maybe length
			for (int j = 0; j < 16; j++) begin
				if (fill_q < s256_pkg::LenPos && j == 14) begin
					blk_q[j] <= bits_q[63:32];
				end else if (fill_q < s256_pkg::LenPos && j == 15) begin
					blk_q[j] <= bits_q[31:0];
				end else if (zero_blk_q || 4'(j) > fill_q[5:2]) begin
					blk_q[j] <= '0;
				end else if (4'(j) == fill_q[5:2]) begin
					unique case (fill_q[1:0])
						2'd0: blk_q[j] <= {s256_pkg::PadByte, 24'd0};
						2'd1: blk_q[j] <= {blk_q[j][7:0], s256_pkg::PadByte, 16'd0};
						2'd2: blk_q[j] <= {blk_q[j][15:0], s256_pkg::PadByte, 8'd0};
						default: blk_q[j] <= {blk_q[j][23:0], s256_pkg::PadByte};
					endcase
				end
			end
		end
		if (state_q == s256_pkg::ST_ROUND) begin
			for (int j = 0; j < 15; j++) blk_q[j] <= blk_q[j+1];
			blk_q[15] <= w_cur;
			wk_q[0] <= t1 + t2;
			wk_q[1] <= wk_q[0];
			wk_q[2] <= wk_q[1];
			wk_q[3] <= wk_q[2];
			wk_q[4] <= wk_q[3] + t1;
			wk_q[5] <= wk_q[4];
			wk_q[6] <= wk_q[5];
			wk_q[7] <= wk_q[6];
		end
		if (start_comp) begin
			for (int i = 0; i < 8; i++) wk_q[i] <= chain_q[i];
		end
	end

	assign out_ch.valid       = (state_q == s256_pkg::ST_EMIT);
	assign out_ch.digest_word = chain_q[oidx_q];
	assign out_ch.word_index  = oidx_q;
	assign out_ch.last_word   = (oidx_q == 3'd7);

endmodule
